// ===== src/point_box_distance_classifier_macros.svh =====
// Assertion shorthands for the point/box classifier checker.
// Both sample on the rising edge of clk; the first one is off while rst_n is low.
`ifndef POINT_BOX_DISTANCE_CLASSIFIER_MACROS_SVH
`define POINT_BOX_DISTANCE_CLASSIFIER_MACROS_SVH

`define PBDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PBDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pbdc_pkg.sv =====
package pbdc_pkg;

  // field widths
  localparam int COORD_W = 16;
  localparam int COORD_BITS = 16;   // coordinate bits actually used, at most COORD_W
  localparam int SUM_W = 40;
  localparam int CLASS_W = 2;

  // per-feature metric value: a squared gap of COORD_BITS bits (Euclidean) or the gap itself (Manhattan)
  localparam int MET_W = 2 * COORD_BITS;
  localparam int ADD_W = ((MET_W > SUM_W) ? MET_W : SUM_W) + 1;

  // stream packing
  localparam int IN_FIELDS_W = 3 * COORD_W + SUM_W;
  localparam int IN_DATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = CLASS_W + 2 * SUM_W;
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // register port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_METRIC_MODE = '0;

  typedef enum logic {
    METRIC_EUCLID    = 1'b0,
    METRIC_MANHATTAN = 1'b1
  } metric_t;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_OUTSIDE = 2'd0,
    CLASS_TOUCH   = 2'd1,
    CLASS_INSIDE  = 2'd2
  } region_class_t;

  typedef struct packed {
    logic [MET_W-1:0] near_gap;
    logic [MET_W-1:0] far_gap;
    logic [SUM_W-1:0] radius;
    logic             last;
  } gap_beat_t;

  typedef struct packed {
    logic [SUM_W-1:0] far_distance;
    logic [SUM_W-1:0] near_distance;
    region_class_t    region_class;
  } result_t;

endpackage

// ===== src/pbdc_cfg.sv =====
module pbdc_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pbdc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [pbdc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [pbdc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output pbdc_pkg::metric_t                   metric_mode
);
  import pbdc_pkg::*;

  metric_t metric_mode_r;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready && (paddr == ADDR_METRIC_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_mode_r <= METRIC_EUCLID;
    end else if (wr_en) begin
      metric_mode_r <= metric_t'(pwdata[0]);
    end
  end

  assign prdata = (paddr == ADDR_METRIC_MODE) ? {{(CFG_DATA_W-1){1'b0}}, metric_mode_r} : '0;
  assign metric_mode = metric_mode_r;

endmodule

// ===== src/pbdc_gap.sv =====
module pbdc_gap (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pbdc_pkg::metric_t                  metric_mode,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [pbdc_pkg::COORD_W-1:0] point_coord,
  input  logic signed [pbdc_pkg::COORD_W-1:0] box_low,
  input  logic signed [pbdc_pkg::COORD_W-1:0] box_high,
  input  logic [pbdc_pkg::SUM_W-1:0]         radius,
  input  logic                               last_feature,
  output logic                               gap_valid,
  input  logic                               gap_ready,
  output pbdc_pkg::gap_beat_t                gap_beat
);
  import pbdc_pkg::*;

  // input register
  logic                  s1_valid_r;
  logic [COORD_W-1:0]    x_r;
  logic [COORD_W-1:0]    lo_r;
  logic [COORD_W-1:0]    hi_r;
  logic [SUM_W-1:0]      radius_r;
  logic                  last_r;

  // gap register
  logic                  gap_valid_r;
  gap_beat_t             gap_beat_r;
  gap_beat_t             gap_beat_nxt;

  logic                  gap_adv;

  logic [COORD_BITS:0]   x_ext;
  logic [COORD_BITS:0]   lo_ext;
  logic [COORD_BITS:0]   hi_ext;
  logic [COORD_BITS:0]   d_lo;      // low - x
  logic [COORD_BITS:0]   d_hi;      // x - high
  logic [COORD_BITS:0]   neg_lo;
  logic [COORD_BITS:0]   neg_hi;
  logic [COORD_BITS-1:0] mag_lo;
  logic [COORD_BITS-1:0] mag_hi;
  logic [COORD_BITS-1:0] pos_lo;
  logic [COORD_BITS-1:0] pos_hi;
  logic [COORD_BITS-1:0] near_mag;
  logic [COORD_BITS-1:0] far_mag;

  assign gap_adv = !gap_valid_r || gap_ready;
  assign in_ready = !s1_valid_r || gap_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      gap_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (gap_adv) begin
        gap_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      x_r      <= point_coord;
      lo_r     <= box_low;
      hi_r     <= box_high;
      radius_r <= radius;
      last_r   <= last_feature;
    end
    if (gap_adv && s1_valid_r) begin
      gap_beat_r <= gap_beat_nxt;
    end
  end

  // one extra bit so differences of full-range coordinates never wrap
  assign x_ext  = {x_r[COORD_BITS-1], x_r[COORD_BITS-1:0]};
  assign lo_ext = {lo_r[COORD_BITS-1], lo_r[COORD_BITS-1:0]};
  assign hi_ext = {hi_r[COORD_BITS-1], hi_r[COORD_BITS-1:0]};

  assign d_lo = lo_ext - x_ext;
  assign d_hi = x_ext - hi_ext;
  assign neg_lo = -d_lo;
  assign neg_hi = -d_hi;

  // magnitudes never exceed 2^COORD_BITS - 1
  assign mag_lo = d_lo[COORD_BITS] ? neg_lo[COORD_BITS-1:0] : d_lo[COORD_BITS-1:0];
  assign mag_hi = d_hi[COORD_BITS] ? neg_hi[COORD_BITS-1:0] : d_hi[COORD_BITS-1:0];
  assign pos_lo = d_lo[COORD_BITS] ? '0 : d_lo[COORD_BITS-1:0];
  assign pos_hi = d_hi[COORD_BITS] ? '0 : d_hi[COORD_BITS-1:0];

  assign near_mag = (pos_lo > pos_hi) ? pos_lo : pos_hi;
  assign far_mag  = (mag_lo > mag_hi) ? mag_lo : mag_hi;

  always_comb begin
    gap_beat_nxt.radius = radius_r;
    gap_beat_nxt.last   = last_r;
    if (metric_mode == METRIC_EUCLID) begin
      gap_beat_nxt.near_gap = MET_W'(near_mag) * MET_W'(near_mag);
      gap_beat_nxt.far_gap  = MET_W'(far_mag) * MET_W'(far_mag);
    end else begin
      gap_beat_nxt.near_gap = {{(MET_W-COORD_BITS){1'b0}}, near_mag};
      gap_beat_nxt.far_gap  = {{(MET_W-COORD_BITS){1'b0}}, far_mag};
    end
  end

  assign gap_valid = gap_valid_r;
  assign gap_beat = gap_beat_r;

endmodule

// ===== src/pbdc_accum.sv =====
module pbdc_accum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                gap_valid,
  output logic                gap_ready,
  input  pbdc_pkg::gap_beat_t gap_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output pbdc_pkg::result_t   out_result
);
  import pbdc_pkg::*;

  localparam logic [ADD_W-1:0] SUM_MAX_EXT = {{(ADD_W-SUM_W){1'b0}}, {SUM_W{1'b1}}};

  logic [SUM_W-1:0] near_sum_r;
  logic [SUM_W-1:0] near_sum_nxt;
  logic [SUM_W-1:0] far_sum_r;
  logic [SUM_W-1:0] far_sum_nxt;
  logic [SUM_W-1:0] held_radius_r;
  logic [SUM_W-1:0] held_radius_nxt;
  logic             outside_seen_r;
  logic             outside_seen_nxt;
  logic             query_start_r;

  logic             out_valid_r;
  result_t          out_result_r;
  result_t          out_result_nxt;

  logic             out_free;
  logic             consume;
  logic [ADD_W-1:0] near_base;
  logic [ADD_W-1:0] far_base;
  logic [ADD_W-1:0] near_add;
  logic [ADD_W-1:0] far_add;
  logic [ADD_W-1:0] near_gap_ext;
  logic [ADD_W-1:0] radius_ext;

  // only a closing beat needs room in the result register
  assign out_free = !out_valid_r || out_ready;
  assign gap_ready = !gap_beat.last || out_free;
  assign consume = gap_valid && gap_ready;

  // first feature of a query restarts the sums and takes the radius
  assign held_radius_nxt = query_start_r ? gap_beat.radius : held_radius_r;
  assign near_base = query_start_r ? '0 : {{(ADD_W-SUM_W){1'b0}}, near_sum_r};
  assign far_base  = query_start_r ? '0 : {{(ADD_W-SUM_W){1'b0}}, far_sum_r};

  assign near_gap_ext = {{(ADD_W-MET_W){1'b0}}, gap_beat.near_gap};
  assign radius_ext   = {{(ADD_W-SUM_W){1'b0}}, held_radius_nxt};

  assign near_add = near_base + near_gap_ext;
  assign far_add  = far_base + {{(ADD_W-MET_W){1'b0}}, gap_beat.far_gap};

  assign near_sum_nxt = (near_add > SUM_MAX_EXT) ? {SUM_W{1'b1}} : near_add[SUM_W-1:0];
  assign far_sum_nxt  = (far_add > SUM_MAX_EXT) ? {SUM_W{1'b1}} : far_add[SUM_W-1:0];

  assign outside_seen_nxt = (!query_start_r && outside_seen_r) || (near_gap_ext > radius_ext);

  always_comb begin
    out_result_nxt.near_distance = near_sum_nxt;
    out_result_nxt.far_distance  = far_sum_nxt;
    if (outside_seen_nxt) begin
      out_result_nxt.region_class = CLASS_OUTSIDE;
    end else if (far_sum_nxt <= held_radius_nxt) begin
      out_result_nxt.region_class = CLASS_INSIDE;
    end else if (near_sum_nxt <= held_radius_nxt) begin
      out_result_nxt.region_class = CLASS_TOUCH;
    end else begin
      out_result_nxt.region_class = CLASS_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_sum_r     <= '0;
      far_sum_r      <= '0;
      held_radius_r  <= '0;
      outside_seen_r <= 1'b0;
      query_start_r  <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      if (consume) begin
        near_sum_r     <= near_sum_nxt;
        far_sum_r      <= far_sum_nxt;
        held_radius_r  <= held_radius_nxt;
        outside_seen_r <= outside_seen_nxt;
        query_start_r  <= gap_beat.last;
      end
      if (out_free) begin
        out_valid_r <= consume && gap_beat.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && gap_beat.last) begin
      out_result_r <= out_result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_result = out_result_r;

endmodule

// ===== src/point_box_distance_classifier.sv =====
// Classifies an axis-aligned box against a query point and radius, one feature
// (axis) per input beat. Every cycle one beat can be taken unless stalled: the
// input register feeds a gap stage (two subtract/abs/max paths and two 16x16
// squarers, used in Euclidean mode), then an accumulate stage with two saturating
// 40-bit sums and the radius compares. The radius is taken from the first beat of
// a query; the beat with tlast closes it and its result (class, near sum, far
// sum) passes the input, gap and result registers to out_tvalid. A waiting
// result stalls only a following tlast beat once it reaches the accumulate stage;
// other beats keep flowing. metric_mode (register 0) selects squared Euclidean
// (0) or Manhattan (1) gaps and should be written only while the block is idle.
module point_box_distance_classifier (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // point_coord[15:0], box_low[31:16], box_high[47:32], radius[87:48]
  input  logic [pbdc_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tlast,  // last_feature
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // region_class[1:0], near_distance[41:2], far_distance[81:42], zero [87:82]
  output logic [pbdc_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [pbdc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [pbdc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [pbdc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import pbdc_pkg::*;

  metric_t       metric_mode;
  logic          gap_valid;
  logic          gap_ready;
  gap_beat_t     gap_beat;
  result_t       out_result;

  pbdc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .metric_mode (metric_mode)
  );

  pbdc_gap u_gap (
    .clk          (clk),
    .rst_n        (rst_n),
    .metric_mode  (metric_mode),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .point_coord  (in_tdata[COORD_W-1:0]),
    .box_low      (in_tdata[2*COORD_W-1:COORD_W]),
    .box_high     (in_tdata[3*COORD_W-1:2*COORD_W]),
    .radius       (in_tdata[3*COORD_W+SUM_W-1:3*COORD_W]),
    .last_feature (in_tlast),
    .gap_valid    (gap_valid),
    .gap_ready    (gap_ready),
    .gap_beat     (gap_beat)
  );

  pbdc_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .gap_valid  (gap_valid),
    .gap_ready  (gap_ready),
    .gap_beat   (gap_beat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}},
                      out_result.far_distance,
                      out_result.near_distance,
                      out_result.region_class};

endmodule

// ===== src/pbdc_checker.sv =====
`include "point_box_distance_classifier_macros.svh"

module pbdc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pbdc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import pbdc_pkg::*;

  `PBDC_ASSERT_ALWAYS(a_reset_no_out, !rst_n |=> !out_tvalid, "result beat right after reset")
  `PBDC_ASSERT(a_class_legal, out_tvalid |-> out_tdata[1:0] <= CLASS_INSIDE, "bad region class")
  `PBDC_ASSERT(a_far_ge_near, out_tvalid |-> out_tdata[81:42] >= out_tdata[41:2], "far below near")
  `PBDC_ASSERT(a_idle_out_ready, !out_tvalid |-> in_tready, "input stalled with output empty")
  `PBDC_ASSERT(a_stall_hold, out_tvalid && !out_tready |=> $stable(out_tdata), "stalled beat changed")

endmodule

bind point_box_distance_classifier pbdc_checker u_pbdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
